>>> hdl/pud_pkg.sv
// ----------------------------------------------------------------------------
// pud_pkg: shared types and constants for the percent URL decoder
// Word formats, status codes, held-byte codes and hex-digit helpers.
// ----------------------------------------------------------------------------
package pud_pkg;

  // Input word: one raw URI byte and its end flag
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } pud_in_t;

  // Output word: one decoded byte or an error code
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       end_of_run;
  } pud_out_t;

  // Most words one input byte can produce
  localparam int unsigned BURST_MAX = 3;

  // Words produced for one input byte, in order
  typedef struct packed {
    logic [1:0]                  count;
    pud_out_t [BURST_MAX-1:0]    word;
  } pud_burst_t;

  // Status codes
  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  // Held-byte codes
  localparam logic [1:0] HELD_NONE  = 2'd0;
  localparam logic [1:0] HELD_PCT   = 2'd1;
  localparam logic [1:0] HELD_DIGIT = 2'd2;

  // Characters
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  // Length limit after reset
  localparam logic [15:0] MAX_LEN_RESET = 16'd4095;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CHAR_ZERO && c <= CHAR_NINE) ||
           (c >= CHAR_LA && c <= CHAR_LF) ||
           (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      d = c - CHAR_LA + {4'd0, HEX_TEN};
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA + {4'd0, HEX_TEN};
    end
    return d[3:0];
  endfunction

endpackage

>>> hdl/pud_decode.sv
// ----------------------------------------------------------------------------
// pud_decode: escape decoder state and per-byte result logic
// Holds the escape state, the run count and the length limit, and turns one
// registered input byte into up to three output words.
// ----------------------------------------------------------------------------
module pud_decode
  import pud_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic       fire,
  input  pud_in_t    item,
  output pud_burst_t burst
);

  logic [15:0] max_len;
  logic [1:0]  held_count;
  logic [7:0]  held_digit;
  logic [15:0] emitted_count;
  logic        discarding;

  logic [7:0]  cand_byte [BURST_MAX];
  logic [1:0]  cand_n;
  logic        cand_dec;
  logic [1:0]  hold_new;
  logic        set_digit;
  logic        fresh_holds;
  logic        err;
  logic [1:0]  res_n;
  logic [1:0]  ndata;
  logic [16:0] cnt_k;

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  // Candidate bytes to emit, in order
  always_comb begin
    fresh_holds  = (item.in_byte == CHAR_PCT) && !item.is_last;
    cand_byte[0] = item.in_byte;
    cand_byte[1] = item.in_byte;
    cand_byte[2] = item.in_byte;
    cand_n       = 2'd0;
    cand_dec     = 1'b0;
    hold_new     = HELD_NONE;
    set_digit    = 1'b0;
    case (held_count)
      HELD_PCT: begin
        if (is_hex(item.in_byte) && !item.is_last) begin
          set_digit = 1'b1;
          hold_new  = HELD_DIGIT;
        end else begin
          cand_byte[0] = CHAR_PCT;
          if (fresh_holds) begin
            cand_n   = 2'd1;
            hold_new = HELD_PCT;
          end else begin
            cand_n = 2'd2;
          end
        end
      end
      HELD_DIGIT: begin
        if (is_hex(item.in_byte)) begin
          cand_byte[0] = {hex_val(held_digit), hex_val(item.in_byte)};
          cand_dec     = 1'b1;
          cand_n       = 2'd1;
        end else begin
          cand_byte[0] = CHAR_PCT;
          cand_byte[1] = held_digit;
          if (fresh_holds) begin
            cand_n   = 2'd2;
            hold_new = HELD_PCT;
          end else begin
            cand_n = 2'd3;
          end
        end
      end
      default: begin
        if (fresh_holds) begin
          hold_new = HELD_PCT;
        end else begin
          cand_n = 2'd1;
        end
      end
    endcase
  end

  // Length and zero checks, one candidate after another
  always_comb begin
    err   = 1'b0;
    res_n = 2'd0;
    ndata = 2'd0;
    cnt_k = 17'd0;
    burst.word = '0;
    for (int k = 0; k < BURST_MAX; k++) begin
      cnt_k = {1'b0, emitted_count} + 17'(k);
      if (2'(k) < cand_n && !err) begin
        res_n = 2'(k + 1);
        if (cnt_k >= {1'b0, max_len}) begin
          burst.word[k] = '{out_byte: 8'd0, status: STATUS_LONG, end_of_run: 1'b1};
          err = 1'b1;
        end else if (k == 0 && cand_dec && cand_byte[0] == 8'd0) begin
          burst.word[k] = '{out_byte: 8'd0, status: STATUS_ZERO, end_of_run: 1'b1};
          err = 1'b1;
        end else begin
          burst.word[k] = '{out_byte: cand_byte[k], status: STATUS_DATA,
                            end_of_run: 1'b0};
          ndata = ndata + 2'd1;
        end
      end
    end
    // last byte closes the run on its final word
    if (!err && item.is_last && res_n != 2'd0) begin
      burst.word[res_n - 2'd1].end_of_run = 1'b1;
    end
    burst.count = discarding ? 2'd0 : res_n;
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= HELD_NONE;
      emitted_count <= 16'd0;
      discarding    <= 1'b0;
    end else if (fire) begin
      if (discarding) begin
        if (item.is_last) begin
          discarding <= 1'b0;
        end
      end else if (err) begin
        held_count    <= HELD_NONE;
        emitted_count <= 16'd0;
        discarding    <= !item.is_last;
      end else if (item.is_last) begin
        held_count    <= HELD_NONE;
        emitted_count <= 16'd0;
      end else begin
        held_count    <= hold_new;
        emitted_count <= emitted_count + {14'd0, ndata};
      end
    end
  end

  // First hex digit of an escape
  always_ff @(posedge clk) begin
    if (fire && !discarding && set_digit) begin
      held_digit <= item.in_byte;
    end
  end

endmodule

>>> hdl/percent_url_decoder_core.sv
// ----------------------------------------------------------------------------
// percent_url_decoder_core: streaming percent decoder for URI bytes
// Input register, escape decoder and an output queue.
// ----------------------------------------------------------------------------
// Usage:
//   Raw URI bytes enter on in_valid/in_stall/in_data, one word per byte, with
//   is_last set on the final byte. Decoded words leave on out_valid/out_stall/
//   out_data; status tells data from the two error codes and end_of_run marks
//   the final word of a run. cfg_we/cfg_wdata load the output length limit;
//   write it only while the block is idle.
//   Throughput: one input byte per cycle while the queue has room. A byte yields
//   zero to three output words; a broken escape replays up to three, and the
//   output queue of DEPTH words absorbs these bursts, while the output side drains
//   one word a cycle unless out_stall holds it. An accepted byte passes through
//   the input register, then the queue write, then the output register.
//   The input register passes a byte on only when the queue has room for
//   three words, so a stalled receiver backs up into in_stall.
//   Reset clears the queue, the escape state and the run count, and sets the
//   length limit to 4095.
// ----------------------------------------------------------------------------
module percent_url_decoder_core
  import pud_pkg::*;
#(
  parameter int unsigned DEPTH = 8  // output queue words, power of two, >= 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  pud_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pud_out_t    out_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             in_full;
  pud_in_t          in_item;
  logic             room;
  logic             fire;
  pud_burst_t       burst;
  logic [1:0]       push_n;
  logic             pop;
  logic             load;
  pud_out_t         mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic [AW:0]      count_next;

  // Handshake
  assign room     = count <= (AW + 1)'(DEPTH - BURST_MAX);
  assign fire     = in_full && room;
  assign in_stall = in_full && !room;
  assign pop      = out_valid && !out_stall;
  assign load     = (count != '0) && (!out_valid || pop);
  assign push_n   = fire ? burst.count : 2'd0;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item <= in_data;
    end
  end

  pud_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_item),
    .burst     (burst)
  );

  // Output queue: up to three writes, one read per cycle
  assign count_next = count + {{(AW - 1){1'b0}}, push_n} - {{AW{1'b0}}, load};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + {{(AW - 2){1'b0}}, push_n};
      rd_ptr <= rd_ptr + {{(AW - 1){1'b0}}, load};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < BURST_MAX; k++) begin
      if (2'(k) < push_n) begin
        mem[wr_ptr + AW'(k)] <= burst.word[k];
      end
    end
  end

  // Output register, refilled from the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= mem[rd_ptr];
    end
  end

`ifndef SYNTHESIS
  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(DEPTH))
    else $error("output queue overflow");

  // a blocked input byte is kept in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !fire |=> in_full && $stable(in_item))
    else $error("input register lost a blocked byte");

  // every error word closes the run
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_DATA |-> out_data.end_of_run)
    else $error("error word without end of run");
`endif

endmodule

>>> dv/tb_percent_url_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_percent_url_decoder_core: self-checking bench for the URI percent decoder
// Drives URI bytes with random gaps and output stalls, and predicts every
// decoded word. Covers escapes in both cases, broken and cut-off escapes,
// decoded zero and length errors, and several length limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_percent_url_decoder_core;
  import pud_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no word moving
  localparam int unsigned HOLD_CYCLES = 60;    // long receiver hold-off
  localparam int unsigned SETTLE      = 4;     // input reg + queue write
  localparam int unsigned RANDOM_BYTES = 120;

  // Predicts decoded words and checks the output stream against them
  class decode_scoreboard;
    logic [15:0] max_len;
    logic [1:0]  held_cnt;
    logic [7:0]  held_char;
    logic [15:0] emit_cnt;
    bit          dropping;
    bit          cut;
    pud_out_t    want_words[$];
    pud_out_t    step_words[$];
    int unsigned errors;

    function new();
      max_len   = MAX_LEN_RESET;
      held_cnt  = HELD_NONE;
      held_char = 8'd0;
      emit_cnt  = 16'd0;
      dropping  = 1'b0;
      errors    = 0;
    endfunction

    // {is digit, value}; letters a-f / A-F have low nibble 1..6
    static function logic [4:0] nibble_of(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return {1'b1, c[3:0]};
      if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF))
        return {1'b1, c[3:0] + HEX_TEN - 4'd1};
      return 5'd0;
    endfunction

    function void add_word(logic [7:0] v, logic [1:0] st, logic e);
      pud_out_t w;
      w.out_byte   = v;
      w.status     = st;
      w.end_of_run = e;
      step_words.push_back(w);
    endfunction

    // Length check first, then zero check on decoded bytes
    function void emit_byte(logic [7:0] v, bit decoded);
      if (cut) return;
      if (emit_cnt >= max_len) begin
        add_word(8'd0, STATUS_LONG, 1'b1);
        cut = 1'b1;
      end else if (decoded && v == 8'd0) begin
        add_word(8'd0, STATUS_ZERO, 1'b1);
        cut = 1'b1;
      end else begin
        add_word(v, STATUS_DATA, 1'b0);
        emit_cnt++;
      end
    endfunction

    function void take_plain(logic [7:0] c, bit last);
      if (cut) return;
      if (c == CHAR_PCT && !last) held_cnt = HELD_PCT;
      else emit_byte(c, 1'b0);
    endfunction

    function void note_byte(pud_in_t w);
      logic [4:0] dig;
      logic [4:0] first;
      pud_out_t   o;
      bit         last;
      last = w.is_last;
      if (dropping) begin
        if (last) dropping = 1'b0;
        return;
      end
      cut = 1'b0;
      dig = nibble_of(w.in_byte);
      case (held_cnt)
        HELD_PCT: begin
          if (dig[4] && !last) begin
            held_char = w.in_byte;
            held_cnt  = HELD_DIGIT;
          end else begin
            held_cnt = HELD_NONE;
            emit_byte(CHAR_PCT, 1'b0);
            take_plain(w.in_byte, last);
          end
        end
        HELD_DIGIT: begin
          held_cnt = HELD_NONE;
          if (dig[4]) begin
            first = nibble_of(held_char);
            emit_byte({first[3:0], dig[3:0]}, 1'b1);
          end else begin
            // broken escape: replay the held bytes literally
            emit_byte(CHAR_PCT, 1'b0);
            emit_byte(held_char, 1'b0);
            take_plain(w.in_byte, last);
          end
        end
        default: begin
          held_cnt = HELD_NONE;
          take_plain(w.in_byte, last);
        end
      endcase
      if (cut) begin
        held_cnt = HELD_NONE;
        emit_cnt = 16'd0;
        dropping = !last;
      end else if (last) begin
        held_cnt = HELD_NONE;
        emit_cnt = 16'd0;
      end
      // end mark goes on the final word of a URI
      foreach (step_words[i]) begin
        o = step_words[i];
        if (last && !cut && i == step_words.size() - 1) o.end_of_run = 1'b1;
        want_words.push_back(o);
      end
      step_words.delete();
    endfunction

    function void mismatch(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 40) $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_word(pud_out_t got);
      pud_out_t want;
      if (want_words.size() == 0) begin
        errors++;
        if (errors <= 40) $error("word 0x%0h arrived with nothing expected", got);
        return;
      end
      want = want_words.pop_front();
      if (got.out_byte !== want.out_byte) mismatch("out_byte", want.out_byte, got.out_byte);
      if (got.status !== want.status) mismatch("status", want.status, got.status);
      if (got.end_of_run !== want.end_of_run)
        mismatch("end_of_run", want.end_of_run, got.end_of_run);
    endfunction

    function int unsigned pending();
      return want_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pud_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  pud_out_t    out_data;

  decode_scoreboard sb;
  pud_in_t     stream[$];
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned quiet = 0;

  percent_url_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: note accepted bytes, check accepted words, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("[percent_url_decoder_core] ERROR");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches and one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 26);
      end
    end
  end

  task automatic push_char(logic [7:0] c);
    pud_in_t t;
    t.in_byte = c;
    t.is_last = 1'b0;
    stream.push_back(t);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic close_uri();
    pud_in_t t;
    t = stream.pop_back();
    t.is_last = 1'b1;
    stream.push_back(t);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return CHAR_ZERO + 8'(r);
    if (r < 16) return CHAR_LA + 8'(r - 10);
    return CHAR_UA + 8'(r - 16);
  endfunction

  function automatic logic [7:0] other_char();
    logic [7:0] c;
    logic [4:0] n;
    do begin
      c = 8'($urandom_range(0, 255));
      n = decode_scoreboard::nibble_of(c);
    end while (n[4]);
    return c;
  endfunction

  // One URI: mostly plain bytes and good escapes, some broken ones
  task automatic add_uri(int unsigned max_units);
    int unsigned units;
    int unsigned kind;
    units = $urandom_range(1, max_units);
    for (int unsigned u = 0; u < units; u++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        push_char(8'($urandom_range(0, 255)));
      end else if (kind < 75) begin
        push_char(CHAR_PCT);
        if ($urandom_range(0, 19) == 0) begin
          push_char(CHAR_ZERO);
          push_char(CHAR_ZERO);
        end else begin
          push_char(hex_char());
          push_char(hex_char());
        end
      end else if (kind < 87) begin
        push_char(CHAR_PCT);
        push_char(hex_char());
        push_char(other_char());
      end else begin
        push_char(CHAR_PCT);
        push_char(other_char());
      end
    end
    // escape cut short by the end of the URI
    kind = $urandom_range(0, 5);
    if (kind == 0) begin
      push_char(CHAR_PCT);
    end else if (kind == 1) begin
      push_char(CHAR_PCT);
      push_char(hex_char());
    end
    close_uri();
  endtask

  task automatic send_stream();
    pud_in_t w;
    while (stream.size() != 0) begin
      w = stream.pop_front();
      while (!calm && $urandom_range(0, 99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Limit writes only with the block empty
  task automatic set_limit(logic [15:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_len = v;
  endtask

  initial begin : main
    int unsigned phase;
    logic [15:0] lim;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: both cases, replayed percent, cut-off escapes, zero bytes
    push_text("%6f%4F%%41");
    close_uri();
    push_text("%G%4%41%2");
    close_uri();
    push_char(CHAR_PCT);
    close_uri();
    push_char(8'h00);
    push_text("%00");
    push_char(8'hFF);
    close_uri();
    send_stream();

    // length error wins over decoded zero; error on the last byte
    set_limit(16'd1);
    push_text("a%00");
    close_uri();
    send_stream();
    set_limit(16'd0);
    push_text("x");
    close_uri();
    send_stream();

    // Random phases over several limits
    phase = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      case (phase)
        0: lim = 16'hFFFF;
        1: lim = MAX_LEN_RESET;
        2: lim = 16'd3;
        3: lim = 16'd1;
        default: lim = 16'($urandom_range(1, 12));
      endcase
      set_limit(lim);
      calm = (phase == 0);
      for (int k = 0; k < 3; k++) begin
        add_uri(phase == 1 ? 10 : 6);
        if (phase == 1 && k == 0) hold_req = 1'b1;
        if (phase == 2 && k == 1) wait_drained();
        send_stream();
      end
      calm = 1'b0;
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[percent_url_decoder_core] OK");
    end else begin
      $display("[percent_url_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
